### sv/ptts_pkg.sv
`timescale 1ns / 1ps
// shared types and codes of the periodic task tick scheduler
package ptts_pkg;

	// item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// policy codes, the fourth code behaves as rate monotonic
	localparam logic [1:0] POL_RM  = 2'd0;
	localparam logic [1:0] POL_EDF = 2'd1;
	localparam logic [1:0] POL_LLF = 2'd2;

	// configuration port
	localparam int APB_AW      = 3;
	localparam int REG_SEL_BIT = 2;
	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_ACTIVE = 1'b1;

	// field widths fixed at the ports
	localparam int IDX_W   = 3;
	localparam int VAL_W   = 16;
	localparam int MASK_W  = 8;
	localparam int MISS_W  = 16;
	localparam logic [MISS_W-1:0] MISS_LIMIT = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_COMMIT,
		ST_DONE
	} sched_state_t;

endpackage

### sv/ptts_if.sv
`timescale 1ns / 1ps
// item and result channel interfaces of the tick scheduler
interface ptts_item_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [2:0]  service_index;
	logic [15:0] service_period;
	logic [15:0] service_budget;

	modport source (output valid, opcode, service_index, service_period, service_budget,
		input ready);
	modport sink (input valid, opcode, service_index, service_period, service_budget,
		output ready);
endinterface

interface ptts_result_if;
	logic        valid;
	logic        ready;
	logic        run_valid;
	logic [2:0]  run_index;
	logic [7:0]  miss_mask;
	logic [15:0] miss_total;

	modport source (output valid, run_valid, run_index, miss_mask, miss_total, input ready);
	modport sink (input valid, run_valid, run_index, miss_mask, miss_total, output ready);
endinterface

### sv/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// periodic task tick scheduler: service tables, walk sequencer, result register
//
//  channel   direction  transfer when            carries
//  item      in         item.valid & item.ready  opcode, service_index/period/budget
//  result    out        result.valid & ready     run_valid, run_index, miss_mask, miss_total
//  apb       in/out     psel & penable & pwrite  policy_mode (0x0), active_services (0x4)
//
// a load item is written at its transfer, so loads go at one per cycle while idle
// a tick item walks live = min(active_services, MAX_SERVICES) services in ST_WALK, each
// through the shared compare and update unit, then ends the walk; ST_COMMIT bumps the chosen
// run count and ST_DONE hands over to the result register
// the result register frees the sequencer, so the next item is taken while a result waits
// a stalled result holds the sequencer in its hand-over state until the register frees
// reset clears all tables, the miss total and the configuration (active count of one)
module periodic_task_tick_scheduler
	import ptts_pkg::*;
#(
	parameter int MAX_SERVICES = 8,
	parameter int TIME_WIDTH   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	ptts_item_if.sink          item,
	ptts_result_if.source      result
);

	localparam int TW = TIME_WIDTH;
	localparam int IW = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
	localparam int CW = $clog2(MAX_SERVICES + 1);
	localparam int KW = TIME_WIDTH + 2;

	// configuration registers
	logic [1:0] policy_q;
	logic [3:0] active_q;
	logic       cfg_write;
	logic       cfg_sel;

	// service tables
	logic [TW-1:0] per_q [MAX_SERVICES];
	logic [TW-1:0] bud_q [MAX_SERVICES];
	logic [TW-1:0] dl_q  [MAX_SERVICES];
	logic [TW-1:0] run_q [MAX_SERVICES];
	logic [MISS_W-1:0] miss_count_q;

	// sequencer
	sched_state_t state_q, state_d;
	logic [CW-1:0] walk_q;
	logic [CW-1:0] live_n;
	logic          have_q;
	logic [IW-1:0] pick_q;
	logic signed [KW-1:0] best_q;
	logic [TW-1:0] best_run_q;
	logic [MASK_W-1:0] mask_q;

	// result register
	logic              out_valid_q;
	logic              run_valid_q;
	logic [IDX_W-1:0]  run_index_q;
	logic [MASK_W-1:0] miss_mask_q;
	logic [MISS_W-1:0] miss_total_q;

	// control strobes
	logic item_fire, load_fire, tick_fire, walk_step, commit_step, out_load;
	logic load_in_range;
	logic [IW-1:0] load_idx;
	logic [31:0]   load_idx_ext;

	// walk unit
	logic [IW-1:0] wi;
	logic [TW-1:0] d_cur, p_cur, b_cur, r_cur, d1, r1;
	logic          expire, miss, elig, keyed, take;
	logic signed [KW-1:0] key_edf, key_llf, key;
	logic [MASK_W-1:0] miss_bit;
	logic [31:0]   pick_ext;

	// ---------------- configuration port ----------------
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign cfg_sel   = paddr[REG_SEL_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RM;
			active_q <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_sel)
				REG_POLICY: policy_q <= pwdata[1:0];
				REG_ACTIVE: active_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_POLICY: prdata = {30'd0, policy_q};
			REG_ACTIVE: prdata = {28'd0, active_q};
			default:    prdata = '0;
		endcase
	end

	// services taking part, the active count saturates at the table depth
	assign live_n = ({2'b00, active_q} > 6'(MAX_SERVICES)) ? CW'(MAX_SERVICES) : CW'(active_q);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		item.ready  = 1'b0;
		walk_step   = 1'b0;
		commit_step = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && item.opcode == OP_TICK) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_q == live_n) state_d = ST_COMMIT;
				else                  walk_step = 1'b1;
			end
			ST_COMMIT: begin
				commit_step = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign item_fire = item.valid & item.ready;
	assign load_fire = item_fire & (item.opcode == OP_LOAD);
	assign tick_fire = item_fire & (item.opcode == OP_TICK);

	// load index: entries past the table depth are dropped
	assign load_idx_ext  = 32'(item.service_index);
	assign load_in_range = load_idx_ext < 32'(MAX_SERVICES);
	assign load_idx      = load_idx_ext[IW-1:0];

	// ---------------- shared walk unit, one service a cycle ----------------
	assign wi     = walk_q[IW-1:0];
	assign d_cur  = dl_q[wi];
	assign p_cur  = per_q[wi];
	assign b_cur  = bud_q[wi];
	assign r_cur  = run_q[wi];

	// period boundary: reload, flag a short run, restart the run count
	assign expire = (d_cur == '0);
	assign d1     = expire ? p_cur : d_cur;
	assign miss   = expire && (r_cur < b_cur);
	assign r1     = expire ? '0 : r_cur;
	assign elig   = r1 < b_cur;

	// deadline key and laxity key (deadline less remaining budget, signed)
	assign key_edf = $signed({2'b00, d1});
	assign key_llf = $signed({2'b00, d1}) - $signed({2'b00, b_cur}) + $signed({2'b00, r1});
	assign key     = (policy_q == POL_LLF) ? key_llf : key_edf;
	assign keyed   = (policy_q == POL_EDF) || (policy_q == POL_LLF);

	// rate monotonic and the spare code keep the first unfinished service, EDF and LLF keep a strict minimum
	assign take = elig && (!have_q || (keyed && (key < best_q)));

	always_comb begin
		miss_bit = '0;
		for (int k = 0; k < MASK_W; k++) begin
			if (int'(walk_q) == k) miss_bit[k] = miss;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_SERVICES; k++) begin
				per_q[k] <= '0;
				bud_q[k] <= '0;
				dl_q[k]  <= '0;
				run_q[k] <= '0;
			end
			miss_count_q <= '0;
			walk_q       <= '0;
			have_q       <= 1'b0;
			pick_q       <= '0;
			best_q       <= '0;
			best_run_q   <= '0;
			mask_q       <= '0;
		end else begin
			if (load_fire && load_in_range) begin
				per_q[load_idx] <= TW'(item.service_period);
				bud_q[load_idx] <= TW'(item.service_budget);
				dl_q[load_idx]  <= TW'(item.service_period);
				run_q[load_idx] <= '0;
			end
			if (tick_fire) begin
				walk_q <= '0;
				have_q <= 1'b0;
				mask_q <= '0;
			end
			if (walk_step) begin
				// deadline decrement folds into the same write-back
				dl_q[wi]  <= d1 - 1'b1;
				run_q[wi] <= r1;
				walk_q    <= walk_q + 1'b1;
				mask_q    <= mask_q | miss_bit;
				if (miss && miss_count_q != MISS_LIMIT) miss_count_q <= miss_count_q + 1'b1;
				if (take) begin
					have_q     <= 1'b1;
					pick_q     <= wi;
					best_q     <= key;
					best_run_q <= r1;
				end
			end
			// chosen service runs this tick
			if (commit_step && have_q) run_q[pick_q] <= best_run_q + 1'b1;
		end
	end

	// ---------------- result register ----------------
	assign pick_ext = 32'(pick_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			run_valid_q  <= have_q;
			run_index_q  <= have_q ? pick_ext[IDX_W-1:0] : '0;
			miss_mask_q  <= mask_q;
			miss_total_q <= miss_count_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.run_valid  = run_valid_q;
	assign result.run_index  = run_index_q;
	assign result.miss_mask  = miss_mask_q;
	assign result.miss_total = miss_total_q;

	// ---------------- assertions ----------------
	// a fresh result only ever comes from the hand-over state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside hand-over");

	// the miss total only moves up by one at a time
	a_miss_step: assert property (@(posedge clk) disable iff (!arst_n)
		(miss_count_q != $past(miss_count_q)) |-> (miss_count_q == $past(miss_count_q) + 1'b1))
		else $error("miss total moved by other than one");

	// the walk never passes the services taking part
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (walk_q <= live_n))
		else $error("walk index past live count");

endmodule

### tb/sv/periodic_task_tick_scheduler_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the periodic task tick scheduler
module periodic_task_tick_scheduler_tb
	import ptts_pkg::*;
();

	localparam int N_SERVICES    = 8;
	localparam int CLK_PERIOD    = 2;
	localparam int RESET_CYCLES  = 12;
	// settle wait after the owed reports, long enough for the longest tick walk
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 800;
	// the unused fourth policy code, which the block runs as rate monotonic
	localparam logic [1:0] POL_SPARE = 2'd3;

	typedef logic [VAL_W-1:0] tick_t;

	// what one tick reports
	typedef struct packed {
		logic              run_valid;
		logic [IDX_W-1:0]  run_index;
		logic [MASK_W-1:0] miss_mask;
		logic [MISS_W-1:0] miss_total;
	} tick_report_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	ptts_item_if   item_bus();
	ptts_result_if result_bus();

	periodic_task_tick_scheduler #(
		.MAX_SERVICES(N_SERVICES),
		.TIME_WIDTH  (VAL_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.item   (item_bus),
		.result (result_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// shadow copy of the scheduler tables and registers
	tick_t             period_mirror   [N_SERVICES];
	tick_t             budget_mirror   [N_SERVICES];
	tick_t             deadline_mirror [N_SERVICES];
	tick_t             runs_mirror     [N_SERVICES];
	logic [MISS_W-1:0] miss_mirror;
	logic [1:0]        policy_mirror;
	logic [3:0]        active_mirror;

	// reports still owed by the block, oldest first
	tick_report_t pending_reports[$];

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int items_sent;
	int loads_seen;
	int ticks_seen;
	int reports_checked;
	int register_writes;
	int quiet_cycles;

	// one tick of the schedule: period boundaries, selection, countdown
	function automatic tick_report_t schedule_tick();
		tick_report_t rep;
		int live;
		int pick;
		int best;
		int key;
		int dl;
		int bd;
		int rn;
		rep  = '0;
		live = (int'(active_mirror) > N_SERVICES) ? N_SERVICES : int'(active_mirror);
		pick = -1;
		best = 0;
		// services at their deadline start a new period, short ones count as misses
		for (int s = 0; s < live; s++) begin
			if (deadline_mirror[s] == '0) begin
				deadline_mirror[s] = period_mirror[s];
				if (runs_mirror[s] < budget_mirror[s]) begin
					rep.miss_mask[s] = 1'b1;
					if (miss_mirror != MISS_LIMIT)
						miss_mirror++;
				end
				runs_mirror[s] = '0;
			end
		end
		// pick among unfinished services, strict less keeps ties on the lower index
		for (int s = 0; s < live; s++) begin
			if (runs_mirror[s] >= budget_mirror[s])
				continue;
			dl = int'(deadline_mirror[s]);
			bd = int'(budget_mirror[s]);
			rn = int'(runs_mirror[s]);
			case (policy_mirror)
				POL_EDF: key = dl;
				POL_LLF: key = dl - (bd - rn);
				default: key = 0;
			endcase
			if (pick < 0 || key < best) begin
				pick = s;
				best = key;
			end
		end
		if (pick >= 0) begin
			runs_mirror[pick]++;
			rep.run_valid = 1'b1;
			rep.run_index = IDX_W'(pick);
		end
		for (int s = 0; s < live; s++)
			deadline_mirror[s]--;
		rep.miss_total = miss_mirror;
		return rep;
	endfunction

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	// item transfers update the shadow state, ticks queue a report
	always @(posedge clk) begin
		if (arst_n && item_bus.valid && item_bus.ready) begin
			if (item_bus.opcode == OP_LOAD) begin
				period_mirror[item_bus.service_index]   = item_bus.service_period;
				budget_mirror[item_bus.service_index]   = item_bus.service_budget;
				deadline_mirror[item_bus.service_index] = item_bus.service_period;
				runs_mirror[item_bus.service_index]     = '0;
				loads_seen++;
			end else begin
				pending_reports.push_back(schedule_tick());
				ticks_seen++;
			end
		end
	end

	// each result transfer against the oldest owed report
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: result with nothing owed, expected none, actual %0h/%0h/%0h/%0h",
					$time, result_bus.run_valid, result_bus.run_index,
					result_bus.miss_mask, result_bus.miss_total);
				fail_count++;
			end else begin
				check_field("run_valid", 32'(pending_reports[0].run_valid),
					32'(result_bus.run_valid));
				check_field("run_index", 32'(pending_reports[0].run_index),
					32'(result_bus.run_index));
				check_field("miss_mask", 32'(pending_reports[0].miss_mask),
					32'(result_bus.miss_mask));
				check_field("miss_total", 32'(pending_reports[0].miss_total),
					32'(result_bus.miss_total));
				void'(pending_reports.pop_front());
				reports_checked++;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk)
		result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

	// stall watchdog, any transfer or register access restarts it
	always @(posedge clk) begin
		if (!arst_n || psel || (item_bus.valid && item_bus.ready)
				|| (result_bus.valid && result_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one item transfer, with an optional random gap ahead of it
	task automatic send_item(logic op, logic [IDX_W-1:0] idx, tick_t per, tick_t bud);
		if ($urandom_range(99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_bus.valid          <= 1'b1;
		item_bus.opcode         <= op;
		item_bus.service_index  <= idx;
		item_bus.service_period <= per;
		item_bus.service_budget <= bud;
		do @(posedge clk); while (!item_bus.ready);
		items_sent++;
	endtask

	task automatic load_service(logic [IDX_W-1:0] idx, tick_t per, tick_t bud);
		send_item(OP_LOAD, idx, per, bud);
	endtask

	// the unused fields of a tick carry noise
	task automatic tick();
		send_item(OP_TICK, IDX_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
	endtask

	// idle the item side, collect every owed report, then let the walk finish
	task automatic settle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic reg_code,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= APB_AW'(reg_code) << REG_SEL_BIT;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(logic reg_code);
		logic [31:0] readback;
		logic [31:0] want;
		want = (reg_code == REG_POLICY) ? 32'(policy_mirror) : 32'(active_mirror);
		apb_access(1'b0, reg_code, '0, readback);
		check_field(reg_code == REG_POLICY ? "policy_mode readback" : "active_services readback",
			want, readback);
	endtask

	// unused upper data bits carry noise, the block keeps the low ones only
	task automatic write_register(logic reg_code, logic [3:0] value);
		logic [31:0] wdata;
		logic [31:0] unused;
		wdata = $urandom();
		if (reg_code == REG_POLICY) begin
			wdata[1:0]    = value[1:0];
			policy_mirror = value[1:0];
		end else begin
			wdata[3:0]    = value;
			active_mirror = value;
		end
		apb_access(1'b1, reg_code, wdata, unused);
		register_writes++;
		check_register(reg_code);
	endtask

	task automatic configure(logic [1:0] pol, logic [3:0] act);
		settle();
		write_register(REG_POLICY, {2'b00, pol});
		write_register(REG_ACTIVE, act);
	endtask

	// registers come up at their reset values, a tick on empty tables is slack
	task automatic test_reset_values();
		check_register(REG_POLICY);
		check_register(REG_ACTIVE);
		tick();
	endtask

	task automatic test_directed_cases();
		// no service takes part
		configure(POL_EDF, 4'd0);
		tick();
		// spare policy code, active count above the table size, field extremes,
		// zero period wrapping its countdown, zero budget never running
		configure(POL_SPARE, 4'd15);
		load_service(3'd0, 16'hFFFF, 16'hFFFF);
		load_service(3'd7, 16'd1, 16'd0);
		load_service(3'd3, 16'd0, 16'd1);
		load_service(3'd5, 16'd2, 16'd2);
		repeat (4) tick();
		// least laxity with tight and loose services
		configure(POL_LLF, 4'd8);
		load_service(3'd1, 16'd3, 16'd3);
		load_service(3'd2, 16'd6, 16'd1);
		repeat (3) tick();
		configure(POL_EDF, 4'd8);
		repeat (3) tick();
		// services above the active count keep their counters
		configure(POL_RM, 4'd4);
		repeat (3) tick();
	endtask

	// one random scenario: settings, a table of short periods, a run of ticks
	task automatic random_scenario();
		int pick;
		int base;
		int per;
		int n_ticks;
		logic [3:0] act;
		pick = $urandom_range(99);
		if (pick < 10)
			act = 4'd0;
		else if (pick < 20)
			act = 4'($urandom_range(N_SERVICES + 1, 15));
		else
			act = 4'($urandom_range(1, N_SERVICES));
		configure(2'($urandom_range(3)), act);
		base = $urandom_range(N_SERVICES - 1);
		for (int s = 0; s < N_SERVICES; s++) begin
			if ($urandom_range(9) < 8) begin
				per = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 24);
				load_service(IDX_W'((s + base) % N_SERVICES), VAL_W'(per),
					VAL_W'($urandom_range(0, per + 2)));
			end
		end
		n_ticks = $urandom_range(16, 48);
		repeat (n_ticks) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				// full-range load, long periods and budgets
				load_service(IDX_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
			end else if (pick < 9) begin
				per = $urandom_range(1, 24);
				load_service(IDX_W'($urandom), VAL_W'(per), VAL_W'($urandom_range(0, per)));
			end else begin
				tick();
			end
		end
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
		int start;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = items_sent;
		while (items_sent - start < n_items)
			random_scenario();
	endtask

	initial begin
		arst_n                  <= 1'b0;
		psel                    <= 1'b0;
		penable                 <= 1'b0;
		pwrite                  <= 1'b0;
		paddr                   <= '0;
		pwdata                  <= '0;
		item_bus.valid          <= 1'b0;
		item_bus.opcode         <= OP_LOAD;
		item_bus.service_index  <= '0;
		item_bus.service_period <= '0;
		item_bus.service_budget <= '0;
		for (int s = 0; s < N_SERVICES; s++) begin
			period_mirror[s]   = '0;
			budget_mirror[s]   = '0;
			deadline_mirror[s] = '0;
			runs_mirror[s]     = '0;
		end
		miss_mirror     = '0;
		policy_mirror   = POL_RM;
		active_mirror   = 4'd1;
		send_idle_pct   = 9;
		recv_idle_pct   = 59;
		fail_count      = 0;
		items_sent      = 0;
		loads_seen      = 0;
		ticks_seen      = 0;
		reports_checked = 0;
		register_writes = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_cases();
		test_random_traffic(9, 59, RANDOM_ITEMS / 3);
		test_random_traffic(59, 9, RANDOM_ITEMS / 3);
		test_random_traffic(0, 0, RANDOM_ITEMS / 3);
		settle();

		if (pending_reports.size() != 0) begin
			$display("%0t: %0d reports never arrived", $time, pending_reports.size());
			fail_count++;
		end
		$display("covered %0d loads and %0d ticks, %0d reports checked, %0d register writes",
			loads_seen, ticks_seen, reports_checked, register_writes);
		$display("all four policy codes, active counts 0 to 15, three idle patterns");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
sv/ptts_pkg.sv
sv/ptts_if.sv
sv/periodic_task_tick_scheduler.sv
tb/sv/periodic_task_tick_scheduler_tb.sv
